FILE: rtl/mbet_pkg.sv
// Shared types and fixed-point constants for the escape-time engine.
`default_nettype none

package mbet_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;

  // Intermediate width: four integer bits above the coordinate, capped at 64.
  localparam int IW = (COORD_WIDTH + 4 > 64) ? 64 : COORD_WIDTH + 4;

  typedef logic signed [IW-1:0] inter_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic                   in_set;
  } result_t;

  localparam inter_t IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam inter_t IMIN = {1'b1, {(IW-1){1'b0}}};

  localparam inter_t ONE       = (FRAC_BITS >= IW - 1) ? IMAX :
                                 inter_t'(64'd1 << FRAC_BITS);
  localparam inter_t QUARTER   = (FRAC_BITS - 2 >= IW - 1) ? IMAX :
                                 inter_t'(64'd1 << (FRAC_BITS - 2));
  localparam inter_t SIXTEENTH = (FRAC_BITS - 4 >= IW - 1) ? IMAX :
                                 inter_t'(64'd1 << (FRAC_BITS - 4));
  localparam inter_t FOUR      = (FRAC_BITS + 2 >= IW - 1) ? IMAX :
                                 inter_t'(64'd4 << FRAC_BITS);

  localparam count_t MAX_ITER_RESET = COUNT_WIDTH'(100);

endpackage

`default_nettype wire

FILE: rtl/mbet_mul.sv
// Shared fixed-point multiplier: two half-width partial products, shift, saturate.
`default_nettype none

module mbet_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mbet_pkg::inter_t a,
  input  mbet_pkg::inter_t b,
  output logic            done,
  output mbet_pkg::inter_t res
);
  import mbet_pkg::*;

  localparam int H   = IW / 2;
  localparam int PPW = 2 * IW - H + 1;
  localparam int PW  = 2 * IW;

  typedef enum logic [1:0] {M_IDLE, M_HI, M_ADD} ph_t;

  ph_t                     ph;
  logic signed [PPW-1:0]   pp;
  logic signed [PW-1:0]    acc;
  logic signed [PW-1:0]    pp_ext;
  logic signed [PW-1:0]    sh;
  inter_t                  a_q;
  logic signed [IW-H-1:0]  bh_q;
  logic                    fits;

  assign pp_ext = {{(PW-PPW){pp[PPW-1]}}, pp};
  assign sh     = acc >>> FRAC_BITS;
  assign fits   = (&sh[PW-1:IW-1]) || !(|sh[PW-1:IW-1]);

  always_comb begin
    if (fits) begin
      res = sh[IW-1:0];
    end else begin
      res = sh[PW-1] ? IMIN : IMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        M_IDLE: begin
          if (start) begin
            // low half of b taken as unsigned
            pp   <= a * $signed({1'b0, b[H-1:0]});
            a_q  <= a;
            bh_q <= b[IW-1:H];
            ph   <= M_HI;
          end
        end
        M_HI: begin
          acc <= pp_ext;
          pp  <= a_q * bh_q;
          ph  <= M_ADD;
        end
        M_ADD: begin
          acc  <= acc + (pp_ext <<< H);
          ph   <= M_IDLE;
          done <= 1'b1;
        end
        default: begin
          ph <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
// Top level of the escape-time engine: sequencer, register file and output register.
//
//  channel   direction  handshake             word
//  in        input      in_valid / in_ready   point_t  {c_real, c_imag}
//  out       output     out_valid / out_ready result_t {iteration_count, in_set}
//  cfg       input      cfg_valid / cfg_ready max_iterations (COUNT_WIDTH bits)
//
// One point at a time. Every product goes through the single shared multiplier;
// a loop iteration is three products plus one update state.
// Early tests settle points in the cardioid and points far outside before the loop.
// Reset restores max_iterations to 100 and idles the sequencer; no clearing pass.
// The finished word waits in the output register, so the next point is taken
// while out_ready is low; a new result waits only for that register to drain.
`default_nettype none

module mandelbrot_escape_time (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbet_pkg::point_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mbet_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [mbet_pkg::COUNT_WIDTH-1:0] cfg_data
);
  import mbet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_Y2, S_XS2, S_QR, S_LHS, S_RHS, S_XP2, S_CX2,
    S_ZX2, S_ZY2, S_T, S_UPD, S_DONE
  } state_t;

  // Saturating add and subtract on the intermediate format.
  function automatic inter_t sadd(input inter_t x, input inter_t y);
    logic signed [IW:0] s;
    s = {x[IW-1], x} + {y[IW-1], y};
    if (s[IW] != s[IW-1]) begin
      return s[IW] ? IMIN : IMAX;
    end
    return s[IW-1:0];
  endfunction

  function automatic inter_t ssub(input inter_t x, input inter_t y);
    logic signed [IW:0] s;
    s = {x[IW-1], x} - {y[IW-1], y};
    if (s[IW] != s[IW-1]) begin
      return s[IW] ? IMIN : IMAX;
    end
    return s[IW-1:0];
  endfunction

  state_t state;
  logic   issue;
  count_t max_iterations;
  count_t limit;
  count_t n;
  count_t n_inc;

  // point and working registers
  inter_t cx, cy, xs, xp, y2, q, r2, lhs;
  inter_t zx, zy, zx2, zy2, d, prod2, diff;
  logic   small_mag;

  // shared multiplier
  logic   mul_start;
  logic   mul_done;
  inter_t mul_a, mul_b, mul_res;
  inter_t cr_ext;

  assign cr_ext    = inter_t'(in_data.c_real);
  assign limit     = (max_iterations == '0) ? COUNT_WIDTH'(1) : max_iterations;
  assign n_inc     = n + COUNT_WIDTH'(1);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mul_start = issue;

  // Operand select: the state names the product being formed.
  always_comb begin
    case (state)
      S_Y2:    begin mul_a = cy;      mul_b = cy;  end
      S_XS2:   begin mul_a = xs;      mul_b = xs;  end
      S_LHS:   begin mul_a = q;       mul_b = r2;  end
      S_RHS:   begin mul_a = QUARTER; mul_b = y2;  end
      S_XP2:   begin mul_a = xp;      mul_b = xp;  end
      S_CX2:   begin mul_a = cx;      mul_b = cx;  end
      S_ZX2:   begin mul_a = zx;      mul_b = zx;  end
      S_ZY2:   begin mul_a = zy;      mul_b = zy;  end
      S_T:     begin mul_a = d;       mul_b = zy;  end
      default: begin mul_a = '0;      mul_b = '0;  end
    endcase
  end

  mbet_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Configuration register; writes must arrive only while the engine is idle (user's duty, not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iterations <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      issue <= 1'b0;
      // load a finished word when the register is free; drop one the consumer takes
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx    <= cr_ext;
            cy    <= inter_t'(in_data.c_imag);
            xs    <= ssub(cr_ext, QUARTER);
            xp    <= sadd(cr_ext, ONE);
            state <= S_Y2;
            issue <= 1'b1;
          end
        end
        S_Y2: begin
          if (mul_done) begin
            y2    <= mul_res;
            state <= S_XS2;
            issue <= 1'b1;
          end
        end
        S_XS2: begin
          if (mul_done) begin
            q     <= sadd(mul_res, y2);
            state <= S_QR;
          end
        end
        S_QR: begin
          r2    <= sadd(q, xs);
          state <= S_LHS;
          issue <= 1'b1;
        end
        S_LHS: begin
          if (mul_done) begin
            lhs   <= mul_res;
            state <= S_RHS;
            issue <= 1'b1;
          end
        end
        S_RHS: begin
          if (mul_done) begin
            // main cardioid
            if (lhs < mul_res) begin
              n     <= limit;
              state <= S_DONE;
            end else begin
              state <= S_XP2;
              issue <= 1'b1;
            end
          end
        end
        S_XP2: begin
          if (mul_done) begin
            // period-2 bulb
            if (sadd(mul_res, y2) < SIXTEENTH) begin
              n     <= limit;
              state <= S_DONE;
            end else begin
              state <= S_CX2;
              issue <= 1'b1;
            end
          end
        end
        S_CX2: begin
          if (mul_done) begin
            n <= '0;
            if (sadd(mul_res, y2) > FOUR) begin
              state <= S_DONE;
            end else begin
              zx    <= '0;
              zy    <= '0;
              state <= S_ZX2;
              issue <= 1'b1;
            end
          end
        end
        S_ZX2: begin
          if (mul_done) begin
            zx2   <= mul_res;
            d     <= sadd(zx, zx);
            state <= S_ZY2;
            issue <= 1'b1;
          end
        end
        S_ZY2: begin
          if (mul_done) begin
            zy2   <= mul_res;
            state <= S_T;
            issue <= 1'b1;
          end
        end
        S_T: begin
          // squares are settled here; form the difference and the escape test
          diff      <= ssub(zx2, zy2);
          small_mag <= (sadd(zx2, zy2) <= FOUR);
          if (mul_done) begin
            prod2 <= mul_res;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          zy <= sadd(prod2, cy);
          zx <= sadd(diff, cx);
          n  <= n_inc;
          if (small_mag && (n_inc < limit)) begin
            state <= S_ZX2;
            issue <= 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_data.iteration_count <= n;
            out_data.in_set          <= (n == limit);
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The multiplier finishes only while the sequencer waits on a product.
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_Y2 || state == S_XS2 || state == S_LHS ||
                  state == S_RHS || state == S_XP2 || state == S_CX2 ||
                  state == S_ZX2 || state == S_ZY2 || state == S_T))
    else $error("multiplier result outside a product state");

  // A product is launched for one cycle only, never back to back.
  a_issue_pulse: assert property (@(posedge clk) disable iff (rst)
    issue |=> !issue)
    else $error("multiplier launched twice in a row");

  // The loop never runs past the limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (n < limit))
    else $error("iteration count passed the limit");

  // A freshly loaded word carries a flag that matches its count.
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=>
      (out_valid && out_data.in_set == (out_data.iteration_count == limit)))
    else $error("in_set disagrees with iteration_count");
`endif

endmodule

`default_nettype wire
